@@ hdl/lcg48_pkg.sv @@
// shared constants, codes, types and helper functions of the lcg48 random source
package lcg48_pkg;

    // generator constants
    localparam int         MultBits = 35;
    localparam logic [MultBits-1:0] LCG_MULT = 35'h5DEECE66D;
    localparam logic [47:0] LCG_ADD  = 48'hB;

    // operation codes carried in tuser
    localparam logic [2:0] KIND_RESEED  = 3'd0;
    localparam logic [2:0] KIND_RAW     = 3'd1;
    localparam logic [2:0] KIND_BOUNDED = 3'd2;
    localparam logic [2:0] KIND_LONG    = 3'd3;
    localparam logic [2:0] KIND_FLOAT   = 3'd4;
    localparam logic [2:0] KIND_DOUBLE  = 3'd5;

    // shared unit operations
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_MOD  = 1'b1;

    // request to the shared unit
    typedef struct packed {
        logic start;
        logic op;
    } t_arith_req;

    // top bits of a 32-bit draw, 0 for a count of zero, counts above 32 act as 32
    function automatic logic [31:0] draw_top(input logic [47:0] st, input logic [5:0] bits);
        logic [5:0] bc;
        logic [5:0] sh;
        begin
            bc = (bits > 6'd32) ? 6'd32 : bits;
            sh = 6'd32 - bc;
            draw_top = st[47:16] >> sh;
        end
    endfunction

    // bound * r >> 31 for a power-of-two bound, done as a select of shifts
    function automatic logic [30:0] pow2_scale(input logic [31:0] bound, input logic [30:0] r);
        logic [30:0] acc;
        begin
            acc = '0;
            for (int k = 0; k < 31; k++) begin
                if (bound[k]) begin
                    acc = acc | (r >> (31 - k));
                end
            end
            pow2_scale = acc;
        end
    endfunction

endpackage

@@ hdl/lcg48_arith.sv @@
// shared iterative unit: shift-add lcg step and restoring 31-bit modulo on one adder
module lcg48_arith
    import lcg48_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_arith_req  i_req,
    input  logic [47:0] i_state,
    input  logic [30:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_result
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_acc, n_acc;
    logic [47:0] r_mcand, n_mcand;
    logic [31:0] r_rem, n_rem;
    logic [30:0] r_dvd, n_dvd;
    logic [31:0] r_dsor, n_dsor;

    logic [47:0] add_a, add_b, add_sum;
    logic        add_cin;
    logic [31:0] rem_sh;

    // shared adder operand selection
    always_comb begin
        rem_sh = {r_rem[30:0], r_dvd[30]};
        if (r_op == OP_MOD) begin
            add_a   = {16'b0, rem_sh};
            add_b   = {16'hFFFF, ~r_dsor};
            add_cin = 1'b1;
        end else begin
            add_a   = r_acc;
            add_b   = LCG_MULT[r_cnt] ? r_mcand : 48'b0;
            add_cin = 1'b0;
        end
        add_sum = add_a + add_b + {47'b0, add_cin};
    end

    // sequencer for both operations
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dsor  = r_dsor;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy  = 1'b1;
                n_op    = i_req.op;
                n_cnt   = '0;
                n_acc   = LCG_ADD;
                n_mcand = i_state;
                n_rem   = '0;
                n_dvd   = i_dividend;
                n_dsor  = i_divisor;
            end
        end else if (r_op == OP_MOD) begin
            // restoring step: keep the difference when it is not negative
            n_rem = add_sum[47] ? rem_sh : add_sum[31:0];
            n_dvd = {r_dvd[29:0], 1'b0};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd30) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else begin
            // shift-add over the multiplier bits, modulo 2^48
            n_acc   = add_sum;
            n_mcand = {r_mcand[46:0], 1'b0};
            n_cnt   = r_cnt + 6'd1;
            if (r_cnt == 6'(MultBits - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_dsor  <= n_dsor;
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_MOD) ? {16'b0, r_rem} : r_acc;

endmodule

@@ hdl/lcg48_random_source.sv @@
// top level of the 48-bit lcg random source: sequencer, generator state and output register
//
// Input stream: s_axis_tuser carries the operation (reseed, raw bits, bounded int, long,
// float fraction, double fraction); s_axis_tdata carries bit_count and bound. Each accepted
// transfer yields exactly one 64-bit result on the m_axis stream.
// Configuration: i_cfg_we writes i_cfg_wdata into the seed register, used on the next reseed.
// Work per operation: each lcg step runs on the shared shift-add unit. Reseed, unknown
// operations and non-positive bounds give their result without a step. Raw, float and a
// power-of-two bounded draw take one step; long and double take two steps. A bounded
// draw with another bound adds a restoring modulo on the same unit, and each rejected
// draw repeats step and modulo.
// One operation is in work at a time; s_axis_tready is high only while the sequencer idles.
// The result sits in an output register, so the next operation is accepted and
// computed while the previous result still waits; the sequencer holds its finished
// result until that register is free.
// Reset: the seed register clears, the generator state becomes the scrambled zero seed,
// and both streams go idle.
module lcg48_random_source
    import lcg48_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,    // seed_value
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // bit_count [5:0], bound [37:6], zero fill
    input  logic [2:0]  s_axis_tuser,   // kind [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // value [63:0]
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_MOD    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]  r_st, n_st;
    logic [63:0] r_seed;
    logic [47:0] r_lcg, n_lcg;
    logic [2:0]  r_kind, n_kind;
    logic [5:0]  r_bits, n_bits;
    logic [31:0] r_bound, n_bound;
    logic        r_second, n_second;
    logic [31:0] r_hi, n_hi;
    logic [30:0] r_u, n_u;
    logic [63:0] r_val, n_val;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_odata, n_odata;

    t_arith_req  req;
    logic        ar_done;
    logic [47:0] ar_result;

    logic [31:0] in_bound;
    logic [31:0] draw;
    logic [30:0] rem;
    logic [31:0] check;
    logic        bound_pow2;

    lcg48_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_state    (n_lcg),
        .i_dividend (n_u),
        .i_divisor  (r_bound),
        .o_done     (ar_done),
        .o_result   (ar_result)
    );

    assign s_axis_tready = (r_st == ST_IDLE);
    assign in_bound      = s_axis_tdata[37:6];

    // operation sequencer
    always_comb begin
        n_st     = r_st;
        n_lcg    = r_lcg;
        n_kind   = r_kind;
        n_bits   = r_bits;
        n_bound  = r_bound;
        n_second = r_second;
        n_hi     = r_hi;
        n_u      = r_u;
        n_val    = r_val;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        req      = '{start: 1'b0, op: OP_STEP};

        draw       = draw_top(ar_result, r_bits);
        rem        = ar_result[30:0];
        check      = {1'b0, r_u} - {1'b0, rem} + (r_bound - 32'd1);
        bound_pow2 = ((r_bound & (r_bound - 32'd1)) == 32'b0);

        // output register frees up when its transfer completes
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind   = s_axis_tuser;
                    n_bits   = s_axis_tdata[5:0];
                    n_bound  = in_bound;
                    n_second = 1'b0;
                    n_val    = '0;
                    case (s_axis_tuser)
                        KIND_RESEED: begin
                            n_lcg = r_seed[47:0] ^ {13'b0, LCG_MULT};
                            n_st  = ST_FINISH;
                        end
                        KIND_RAW, KIND_LONG, KIND_FLOAT, KIND_DOUBLE: begin
                            req  = '{start: 1'b1, op: OP_STEP};
                            n_st = ST_STEP;
                        end
                        KIND_BOUNDED: begin
                            if (in_bound == 32'b0 || in_bound[31]) begin
                                n_st = ST_FINISH;
                            end else begin
                                req  = '{start: 1'b1, op: OP_STEP};
                                n_st = ST_STEP;
                            end
                        end
                        default: begin
                            n_st = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (ar_done) begin
                    n_lcg = ar_result;
                    case (r_kind)
                        KIND_RAW: begin
                            n_val = {{32{draw[31]}}, draw};
                            n_st  = ST_FINISH;
                        end
                        KIND_BOUNDED: begin
                            if (bound_pow2) begin
                                n_val = {33'b0, pow2_scale(r_bound, ar_result[47:17])};
                                n_st  = ST_FINISH;
                            end else begin
                                n_u  = ar_result[47:17];
                                req  = '{start: 1'b1, op: OP_MOD};
                                n_st = ST_MOD;
                            end
                        end
                        KIND_LONG: begin
                            if (!r_second) begin
                                n_hi     = ar_result[47:16];
                                n_second = 1'b1;
                                req      = '{start: 1'b1, op: OP_STEP};
                            end else begin
                                n_val = {r_hi + {32{ar_result[47]}}, ar_result[47:16]};
                                n_st  = ST_FINISH;
                            end
                        end
                        KIND_FLOAT: begin
                            n_val = {40'b0, ar_result[47:24]};
                            n_st  = ST_FINISH;
                        end
                        default: begin
                            // double fraction: 26 high bits then 27 low bits
                            if (!r_second) begin
                                n_hi     = {6'b0, ar_result[47:22]};
                                n_second = 1'b1;
                                req      = '{start: 1'b1, op: OP_STEP};
                            end else begin
                                n_val = {11'b0, r_hi[25:0], ar_result[47:21]};
                                n_st  = ST_FINISH;
                            end
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (ar_done) begin
                    // reject the draw when the top partial bucket overflows
                    if (check[31]) begin
                        req  = '{start: 1'b1, op: OP_STEP};
                        n_st = ST_STEP;
                    end else begin
                        n_val = {33'b0, rem};
                        n_st  = ST_FINISH;
                    end
                end
            end
            default: begin
                // hand the result to the output register once it is free
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = r_val;
                    n_ovalid = 1'b1;
                    n_st     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_seed   <= '0;
            r_lcg    <= {13'b0, LCG_MULT};
            r_ovalid <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_lcg    <= n_lcg;
            r_ovalid <= n_ovalid;
            r_second <= n_second;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
        r_kind  <= n_kind;
        r_bits  <= n_bits;
        r_bound <= n_bound;
        r_hi    <= n_hi;
        r_u     <= n_u;
        r_val   <= n_val;
        r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
